[rtl/ks01_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ks01_pkg
// shared sizes, field widths and result kind codes for the knapsack solver
// ----------------------------------------------------------------------------
package ks01_pkg;
    // item store depth, row length minus one and value bits kept per item
    localparam int unsigned MAX_ITEMS    = 32;
    localparam int unsigned MAX_CAPACITY = 1023;
    localparam int unsigned VALUE_BITS   = 16;

    localparam int unsigned VAL_W = 16;
    localparam int unsigned WT_W  = 10;
    localparam int unsigned BEST_W = 21;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned IDX_W = 5;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_ITEM    = 1'b1;
endpackage
`default_nettype wire

[rtl/ks01_row_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ks01_row_mem
// best-value row memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module ks01_row_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 22
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/knapsack_01_solver.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knapsack_01_solver
// streaming 0/1 knapsack solver with traceback of the chosen items
// ----------------------------------------------------------------------------
// One shared adder and comparator walks the best-value row from cap down to
// 1 for every stored item, entry by entry: read the entry, read the entry
// one weight below, then compare and write back. From the accepting edge
// o_in_stall stays high through the entry walk, a check at entry 0 and a
// wrap-up step, so a new item is taken only once the last one is through.
// An item beyond MAX_ITEMS is only flagged and not swept. On the last item
// the solver walks the take bits back over every stored item, sets up the
// summary, then offers each result in turn, moving on at each unstalled
// edge, closes after the last one, and finally clears the row one entry per
// cycle. o_in_stall is low only when idle. Capacity is clamped to
// MAX_CAPACITY and sampled on every item; the traceback starts from the
// capacity of the last item. Take bits are kept in a memory of
// MAX_ITEMS*(MAX_CAPACITY+1) entries.
module knapsack_01_solver (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [ks01_pkg::WT_W-1:0]    i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [ks01_pkg::VAL_W-1:0]   i_item_value,
    input  wire logic [ks01_pkg::WT_W-1:0]    i_item_weight,
    input  wire logic                         i_last_item,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_result_kind,
    output logic [ks01_pkg::BEST_W-1:0]       o_best_value,
    output logic [ks01_pkg::CNT_W-1:0]        o_item_count,
    output logic                              o_overflow,
    output logic [ks01_pkg::IDX_W-1:0]        o_item_index,
    output logic [ks01_pkg::VAL_W-1:0]        o_chosen_value,
    output logic [ks01_pkg::WT_W-1:0]         o_chosen_weight,
    output logic                              o_last_result
);
    localparam int unsigned CAP_W = $clog2(ks01_pkg::MAX_CAPACITY + 1);
    localparam int unsigned IT_W  = $clog2(ks01_pkg::MAX_ITEMS);
    localparam int unsigned NC_W  = $clog2(ks01_pkg::MAX_ITEMS + 1);
    localparam int unsigned ROW_W = 22;
    // take bit address is {item slot, capacity entry}
    localparam int unsigned TB_D  = 1 << (IT_W + CAP_W);
    localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(ks01_pkg::MAX_CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_HI, S_RD_LO, S_WAIT, S_CMP, S_TB_RD, S_TB_CHK,
        S_SUM, S_ITEM, S_CLEAR
    } t_state;

    t_state r_state;
    logic [ks01_pkg::WT_W-1:0] r_capacity;
    logic [CAP_W-1:0] r_cap, r_w;
    logic [ks01_pkg::VAL_W-1:0] r_v;
    logic [ks01_pkg::WT_W-1:0] r_wt;
    logic r_last;
    logic [NC_W-1:0] r_count, r_ti, r_nchosen, r_oi;
    logic r_drop;
    logic [ROW_W-1:0] r_hi;
    logic [ks01_pkg::VAL_W-1:0] r_vals [ks01_pkg::MAX_ITEMS];
    logic [ks01_pkg::WT_W-1:0]  r_wts  [ks01_pkg::MAX_ITEMS];
    // capacity each stored item was swept with, take bits above it are not written
    logic [CAP_W-1:0] r_caps [ks01_pkg::MAX_ITEMS];
    logic [IT_W-1:0] r_chosen [ks01_pkg::MAX_ITEMS];
    logic r_tb [TB_D];
    logic r_tb_q;
    logic [ks01_pkg::BEST_W-1:0] r_best;

    // row memory ports
    logic             row_we;
    logic [CAP_W-1:0] row_waddr, row_raddr;
    logic [ROW_W-1:0] row_wdata, row_q;

    ks01_row_mem #(.DEPTH(ks01_pkg::MAX_CAPACITY + 1), .WIDTH(ROW_W)) u_row (
        .i_clk(i_clk), .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_q)
    );

    // capacity in force, clamped to the last row entry
    logic [CAP_W-1:0] eff_cap;
    assign eff_cap = (r_capacity > CAP_MAX) ? CAP_MAX : r_capacity;

    // shared adder/compare unit
    logic [ks01_pkg::VAL_W-1:0] vmask;
    logic [ROW_W:0] cand;
    logic fits, better;
    assign vmask  = (ks01_pkg::VAL_W)'((33'd1 << ks01_pkg::VALUE_BITS) - 33'd1);
    assign fits   = r_wt <= r_w;
    assign cand   = {1'b0, row_q} + (ROW_W + 1)'(r_v);
    assign better = fits && (cand > {1'b0, r_hi});

    logic [CAP_W-1:0] w_lo;
    assign w_lo = r_w - r_wt;

    logic [IT_W-1:0] cur_it;
    assign cur_it = r_count[IT_W-1:0];
    logic [IT_W-1:0] tb_it;
    assign tb_it = IT_W'(r_ti - NC_W'(1));

    // entry 0 and entries above the item's own sweep never hold a take
    logic tb_take;
    assign tb_take = r_tb_q && (r_w != '0) && (r_w <= r_caps[tb_it]);

    always_comb begin
        row_we = 1'b0; row_waddr = r_w; row_wdata = ROW_W'(0); row_raddr = r_w;
        case (r_state)
            S_RD_HI: row_raddr = r_w;
            S_RD_LO: row_raddr = fits ? w_lo : r_w;
            S_CMP: begin
                row_we = better; row_wdata = cand[ROW_W-1:0];
            end
            S_CLEAR: row_we = 1'b1;
            default: row_raddr = r_cap;
        endcase
    end

    // take bit store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP && r_count < NC_W'(ks01_pkg::MAX_ITEMS)) begin
            r_tb[{cur_it, r_w}] <= better;
        end
        r_tb_q <= r_tb[{tb_it, r_w}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_capacity <= '1; r_count <= '0; r_drop <= 1'b0;
            r_w <= CAP_MAX; o_out_valid <= 1'b0; o_in_stall <= 1'b1;
        end else begin
            if (i_cfg_we) r_capacity <= i_cfg_data;
            case (r_state)
                // accept one transaction, store it unless the set is full
                S_IDLE: if (i_in_valid) begin
                    o_in_stall <= 1'b1;
                    r_v <= i_item_value & vmask; r_wt <= i_item_weight;
                    r_last <= i_last_item;
                    r_cap <= eff_cap;
                    r_w <= eff_cap;
                    if (r_count < NC_W'(ks01_pkg::MAX_ITEMS)) begin
                        r_vals[cur_it] <= i_item_value & vmask;
                        r_wts[cur_it] <= i_item_weight;
                        r_caps[cur_it] <= eff_cap;
                        r_state <= S_RD_HI;
                    end else begin
                        r_drop <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_RD_HI: r_state <= (r_w == '0) ? S_WAIT : S_RD_LO;
                S_RD_LO: begin r_hi <= row_q; r_state <= S_CMP; end
                S_CMP: begin
                    r_w <= r_w - CAP_W'(1);
                    r_state <= S_RD_HI;
                end
                S_WAIT: begin
                    // item done, capacity entry for summary is being read
                    if (r_count < NC_W'(ks01_pkg::MAX_ITEMS)) begin
                        r_count <= r_count + NC_W'(1);
                        r_ti <= r_count + NC_W'(1);
                    end else begin
                        r_ti <= r_count;
                    end
                    r_w <= r_cap; r_nchosen <= '0;
                    if (r_last) begin
                        r_state <= S_TB_RD;
                    end else begin
                        r_state <= S_IDLE; o_in_stall <= 1'b0;
                    end
                end
                S_TB_RD: begin
                    r_best <= row_q[ks01_pkg::BEST_W-1:0];
                    r_state <= (r_ti == '0) ? S_SUM : S_TB_CHK;
                end
                // newest item first, step down by its weight when taken
                S_TB_CHK: begin
                    if (tb_take) begin
                        r_chosen[r_nchosen[IT_W-1:0]] <= tb_it;
                        r_nchosen <= r_nchosen + NC_W'(1);
                        r_w <= (r_wts[tb_it] <= r_w) ? r_w - r_wts[tb_it] : '0;
                    end
                    r_ti <= r_ti - NC_W'(1);
                    r_state <= (r_ti == NC_W'(1)) ? S_SUM : S_TB_RD;
                end
                S_SUM: if (!o_out_valid || !i_out_stall) begin
                    o_out_valid <= 1'b1; o_result_kind <= ks01_pkg::KIND_SUMMARY;
                    o_best_value <= r_best; o_item_count <= r_count;
                    o_overflow <= r_drop; o_item_index <= '0; o_chosen_value <= '0;
                    o_chosen_weight <= '0; o_last_result <= (r_nchosen == '0);
                    r_oi <= '0; r_state <= S_ITEM;
                end
                // each unstalled edge takes the shown result and offers the next, or closes after the last
                S_ITEM: if (!i_out_stall) begin
                    if (r_oi == r_nchosen) begin
                        o_out_valid <= 1'b0; r_w <= CAP_MAX; r_state <= S_CLEAR;
                        r_count <= '0; r_drop <= 1'b0;
                    end else begin
                        o_result_kind <= ks01_pkg::KIND_ITEM; o_best_value <= '0;
                        o_item_count <= '0; o_overflow <= 1'b0;
                        o_item_index <= r_chosen[r_oi[IT_W-1:0]];
                        o_chosen_value <= r_vals[r_chosen[r_oi[IT_W-1:0]]];
                        o_chosen_weight <= r_wts[r_chosen[r_oi[IT_W-1:0]]];
                        o_last_result <= (r_oi + NC_W'(1) == r_nchosen);
                        r_oi <= r_oi + NC_W'(1);
                    end
                end
                // zero the whole row, also right after reset
                S_CLEAR: begin
                    r_w <= r_w - CAP_W'(1);
                    if (r_w == '0) begin r_state <= S_IDLE; o_in_stall <= 1'b0; end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
